### rtl/core/lb64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lb64_pkg: shared types for the lenient base64 decoder
// Holds the work entry that the front hands to the back through the queue.
// ----------------------------------------------------------------------------
package lb64_pkg;

  localparam int QUEUE_DEPTH = 4;

  // up to three decoded bytes in output order, their count, and the end mark
  typedef struct packed {
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
    logic [1:0] count;
    logic       eot;
  } entry_t;

endpackage

### rtl/core/lb64_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lb64_front: character classifier and quartet assembler
// Accepts one character a cycle when the queue has room, tracks the quartet
// slot and emits one entry per character that yields bytes or ends the text.
// ----------------------------------------------------------------------------
module lb64_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char,
  input  logic              in_eot,
  output logic              push,
  output lb64_pkg::entry_t  push_entry,
  input  logic              queue_full
);

  localparam logic [1:0] PH0 = 2'd0;
  localparam logic [1:0] PH1 = 2'd1;
  localparam logic [1:0] PH2 = 2'd2;
  localparam logic [1:0] PH3 = 2'd3;

  localparam logic [6:0] CODE_SKIP = 7'd64;
  localparam logic [6:0] CODE_PAD  = 7'd65;

  function automatic logic [6:0] classify(input logic [7:0] ch);
    logic [6:0] code;
    code = CODE_SKIP;
    if (ch inside {[8'h41:8'h5A]}) begin
      code = 7'(ch - 8'h41);
    end else if (ch inside {[8'h61:8'h7A]}) begin
      code = 7'(ch - 8'h61 + 8'd26);
    end else if (ch inside {[8'h30:8'h39]}) begin
      code = 7'(ch - 8'h30 + 8'd52);
    end else if (ch inside {8'h2B, 8'h2D}) begin
      code = 7'd62;
    end else if (ch inside {8'h2F, 8'h5F}) begin
      code = 7'd63;
    end else if (ch == 8'h3D) begin
      code = CODE_PAD;
    end
    return code;
  endfunction

  logic [1:0] slot_phase, slot_phase_next;
  logic [5:0] first_sextet, first_sextet_next;
  logic [5:0] second_sextet, second_sextet_next;
  logic [5:0] third_sextet, third_sextet_next;
  logic       third_was_pad, third_was_pad_next;

  logic [6:0]  code;
  logic        is_pad;
  logic [5:0]  last_sextet;
  logic [23:0] word;
  logic [23:0] flush_word;
  logic        accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign code     = classify(in_char);
  assign is_pad   = (code == CODE_PAD);

  always_comb begin
    slot_phase_next    = slot_phase;
    first_sextet_next  = first_sextet;
    second_sextet_next = second_sextet;
    third_sextet_next  = third_sextet;
    third_was_pad_next = third_was_pad;
    push_entry         = '0;
    last_sextet        = is_pad ? 6'd0 : code[5:0];
    word               = {first_sextet, second_sextet, third_sextet, last_sextet};
    flush_word         = '0;

    if (code != CODE_SKIP) begin
      case (slot_phase)
        PH0: begin
          if (!is_pad) begin
            first_sextet_next = code[5:0];
            slot_phase_next   = PH1;
          end
        end
        PH1: begin
          if (!is_pad) begin
            second_sextet_next = code[5:0];
            slot_phase_next    = PH2;
          end else begin
            slot_phase_next = PH0;
          end
        end
        PH2: begin
          third_was_pad_next = is_pad;
          third_sextet_next  = is_pad ? 6'd0 : code[5:0];
          slot_phase_next    = PH3;
        end
        default: begin
          push_entry.byte0 = word[23:16];
          if (third_was_pad) begin
            push_entry.byte1 = word[7:0];
            push_entry.count = is_pad ? 2'd1 : 2'd2;
          end else begin
            push_entry.byte1 = word[15:8];
            push_entry.byte2 = word[7:0];
            push_entry.count = is_pad ? 2'd2 : 2'd3;
          end
          slot_phase_next    = PH0;
          first_sextet_next  = '0;
          second_sextet_next = '0;
          third_sextet_next  = '0;
          third_was_pad_next = 1'b0;
        end
      endcase
    end

    if (in_eot) begin
      flush_word = {first_sextet_next, second_sextet_next, third_sextet_next, 6'd0};
      if (slot_phase_next == PH2) begin
        push_entry.byte0 = {first_sextet_next, second_sextet_next[5:4]};
        push_entry.count = 2'd1;
      end else if (slot_phase_next == PH3) begin
        push_entry.byte0 = flush_word[23:16];
        push_entry.byte1 = flush_word[15:8];
        push_entry.count = third_was_pad_next ? 2'd1 : 2'd2;
      end
      push_entry.eot     = 1'b1;
      slot_phase_next    = PH0;
      first_sextet_next  = '0;
      second_sextet_next = '0;
      third_sextet_next  = '0;
      third_was_pad_next = 1'b0;
    end
  end

  assign push = accept && ((push_entry.count != 2'd0) || push_entry.eot);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_phase    <= PH0;
      first_sextet  <= '0;
      second_sextet <= '0;
      third_sextet  <= '0;
      third_was_pad <= 1'b0;
    end else if (accept) begin
      slot_phase    <= slot_phase_next;
      first_sextet  <= first_sextet_next;
      second_sextet <= second_sextet_next;
      third_sextet  <= third_sextet_next;
      third_was_pad <= third_was_pad_next;
    end
  end

endmodule

### rtl/core/lb64_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lb64_queue: short entry queue between front and back
// Circular buffer of decode entries with occupancy count.
// ----------------------------------------------------------------------------
module lb64_queue #(
  parameter int DEPTH = lb64_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lb64_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output lb64_pkg::entry_t  head,
  output logic              not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lb64_pkg::entry_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

### rtl/core/lb64_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lb64_back: result serializer
// Walks head entry bytes one per cycle into output register unless stalled.
// ----------------------------------------------------------------------------
module lb64_back (
  input  logic              clk,
  input  logic              rst,
  input  lb64_pkg::entry_t  head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              last_of_run,
  output logic              end_of_output
);

  logic [1:0] index;
  logic [1:0] last_index;
  logic       load;
  logic       at_last;
  logic [7:0] sel_byte;

  assign last_index = (head.count == 2'd0) ? 2'd0 : head.count - 2'd1;
  assign at_last    = (index == last_index);
  assign load       = head_valid && (!out_valid || out_ready);
  assign pop        = load && at_last;

  always_comb begin
    case (index)
      2'd0:    sel_byte = head.byte0;
      2'd1:    sel_byte = head.byte1;
      default: sel_byte = head.byte2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      index     <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      index     <= at_last ? 2'd0 : index + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte      <= (head.count == 2'd0) ? 8'd0 : sel_byte;
      byte_valid    <= (head.count != 2'd0);
      last_of_run   <= at_last;
      end_of_output <= head.eot && at_last;
    end
  end

endmodule

### rtl/core/lenient_base64_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lenient_base64_decoder_top: lenient base64 decoder, both alphabets
// Slave side takes one text character per beat: s_tdata is the character,
// s_tlast marks the last character of the text. Master side gives one result
// per beat: m_tdata is the decoded byte, m_tlast marks the last result of an
// input character, m_tuser carries byte_valid and end_of_output.
// Input beats are taken every cycle while the entry queue has room; each
// character that yields bytes or ends the text leaves one queue entry.
// The back end emits one result per cycle while m_tready is high, so entries
// of up to three bytes set the sustained input rate when the output dominates.
// The first result of a character passes the queue and the output register.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and s_tready drops once QUEUE_DEPTH entries wait.
// Reset clears the quartet state, queue occupancy and the output valid flag.
// ----------------------------------------------------------------------------
module lenient_base64_decoder_top #(
  parameter int QUEUE_DEPTH = lb64_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] byte_valid, [1] end_of_output
  output logic       m_tlast
);

  logic             push;
  lb64_pkg::entry_t push_entry;
  logic             queue_full;
  logic             pop;
  lb64_pkg::entry_t head;
  logic             head_valid;

  lb64_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_char    (s_tdata),
    .in_eot     (s_tlast),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  lb64_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .not_empty  (head_valid)
  );

  lb64_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_byte      (m_tdata),
    .byte_valid    (m_tuser[0]),
    .last_of_run   (m_tlast),
    .end_of_output (m_tuser[1])
  );

endmodule
